@@ src/stack_machine_executor_macros.svh @@
// Assertion macros used by the stack machine executor checker.
// No dependencies.
`ifndef STACK_MACHINE_EXECUTOR_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMX_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stack machine executor check failed");

// Next-cycle implication, disabled during reset.
`define SMX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stack machine executor check failed");

// Next-cycle implication that also holds across reset.
`define SMX_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("stack machine executor check failed");

`endif

@@ src/smx_pkg.sv @@
// Types and constants of the stack machine executor.
// No dependencies; used by smx_front, smx_back, the top level, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package smx_pkg;

   localparam logic [31:0] OPC_NONE = 32'd0;
   localparam logic [31:0] OPC_PUSH = 32'd1;
   localparam logic [31:0] OPC_ADD  = 32'd2;
   localparam logic [31:0] OPC_OUT  = 32'd3;
   localparam logic [31:0] OPC_HLT  = 32'd4;
   localparam logic [31:0] OPC_MUL  = 32'd5;

   localparam logic [2:0] KIND_OUT     = 3'd0;
   localparam logic [2:0] KIND_HALT    = 3'd1;
   localparam logic [2:0] KIND_NONE    = 3'd2;
   localparam logic [2:0] KIND_UNKNOWN = 3'd3;
   localparam logic [2:0] KIND_UNDER   = 3'd4;
   localparam logic [2:0] KIND_OVER    = 3'd5;

   typedef struct packed {
      logic signed [31:0] code_word;
      logic               last_word;
   } smx_req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] value;
   } smx_rsp_type;

   typedef enum logic [2:0] {
      DOP_NOP,
      DOP_PUSHV,
      DOP_ADD,
      DOP_MUL,
      DOP_OUT,
      DOP_EMIT
   } smx_dop_type;

   // Decoded word passed from front to back.
   typedef struct packed {
      smx_dop_type op;
      logic [2:0]  kind;
      logic [31:0] value;
      logic        last;
   } smx_dec_type;

   typedef enum logic {
      BK_ISSUE,
      BK_FINISH
   } smx_bk_state_type;

   typedef enum logic [1:0] {
      FIN_LOAD,
      FIN_ADD,
      FIN_MUL
   } smx_fin_type;

endpackage

`default_nettype wire

@@ src/smx_queue.sv @@
// Small register-based queue with push/full and pop/empty sides.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module smx_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ src/smx_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module smx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ src/smx_front.sv @@
// Front end: accepts program words, tracks push-immediate and halt state,
// and decodes each word into an operation for the back end. Uses smx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smx_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire smx_pkg::smx_req_type req_data,
   input  wire logic                 dq_full,
   output logic                      dq_push,
   output smx_pkg::smx_dec_type      dq_data
);

   logic        pend_ff, pend_in;
   logic        halt_ff, halt_in;
   logic        accept;
   logic [31:0] word;

   assign accept = req_push && !dq_full;
   assign word   = req_data.code_word;

   always_comb begin
      pend_in       = pend_ff;
      halt_in       = halt_ff;
      dq_data.op    = smx_pkg::DOP_NOP;
      dq_data.kind  = smx_pkg::KIND_OUT;
      dq_data.value = word;
      dq_data.last  = req_data.last_word;
      if (halt_ff) begin
         pend_in = 1'b0;
      end else if (pend_ff) begin
         pend_in    = 1'b0;
         dq_data.op = smx_pkg::DOP_PUSHV;
      end else begin
         case (word)
            smx_pkg::OPC_PUSH: begin
               pend_in = 1'b1;
            end
            smx_pkg::OPC_ADD: begin
               dq_data.op = smx_pkg::DOP_ADD;
            end
            smx_pkg::OPC_MUL: begin
               dq_data.op = smx_pkg::DOP_MUL;
            end
            smx_pkg::OPC_OUT: begin
               dq_data.op = smx_pkg::DOP_OUT;
            end
            smx_pkg::OPC_HLT: begin
               halt_in       = 1'b1;
               dq_data.op    = smx_pkg::DOP_EMIT;
               dq_data.kind  = smx_pkg::KIND_HALT;
               dq_data.value = '0;
            end
            smx_pkg::OPC_NONE: begin
               dq_data.op    = smx_pkg::DOP_EMIT;
               dq_data.kind  = smx_pkg::KIND_NONE;
               dq_data.value = '0;
            end
            default: begin
               dq_data.op   = smx_pkg::DOP_EMIT;
               dq_data.kind = smx_pkg::KIND_UNKNOWN;
            end
         endcase
      end
      if (req_data.last_word) begin
         pend_in = 1'b0;
         halt_in = 1'b0;
      end
   end

   // A last word always goes through so the back end clears its stack.
   assign dq_push = accept && ((dq_data.op != smx_pkg::DOP_NOP) || req_data.last_word);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         halt_ff <= 1'b0;
      end else if (accept) begin
         pend_ff <= pend_in;
         halt_ff <= halt_in;
      end
   end

endmodule

`default_nettype wire

@@ src/smx_back.sv @@
// Back end: executes decoded operations on the stack (top entry in a register,
// the rest in smx_ram) and writes result words. Uses smx_pkg, smx_ram.
`timescale 1ns / 1ps
`default_nettype none

module smx_back #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 dq_empty,
   input  wire smx_pkg::smx_dec_type dq_data,
   output logic                      dq_pop,
   input  wire logic                 rq_full,
   output logic                      rq_push,
   output smx_pkg::smx_rsp_type      rq_data
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   smx_pkg::smx_bk_state_type state_ff, state_in;
   smx_pkg::smx_fin_type      fin_ff, fin_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [31:0]               tos_ff, tos_in;
   logic [CW-1:0]             cnt_m1, cnt_m2;
   logic                      wr_en, rd_en;
   logic [31:0]               rd_data;
   logic [31:0]               product;

   assign cnt_m1  = count_ff - CW'(1);
   assign cnt_m2  = count_ff - CW'(2);
   assign product = tos_ff * rd_data;

   smx_ram #(
      .WIDTH (32),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_m1[AW-1:0]),
      .wr_data (tos_ff),
      .rd_en   (rd_en),
      .rd_addr (cnt_m2[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      fin_in        = fin_ff;
      count_in      = count_ff;
      tos_in        = tos_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      dq_pop        = 1'b0;
      rq_push       = 1'b0;
      rq_data.kind  = dq_data.kind;
      rq_data.value = dq_data.value;
      case (state_ff)
         smx_pkg::BK_ISSUE: begin
            if (!dq_empty && !rq_full) begin
               dq_pop = 1'b1;
               case (dq_data.op)
                  smx_pkg::DOP_PUSHV: begin
                     if (count_ff == CW'(STACK_DEPTH)) begin
                        rq_push       = 1'b1;
                        rq_data.kind  = smx_pkg::KIND_OVER;
                        rq_data.value = smx_pkg::OPC_PUSH;
                     end else begin
                        wr_en    = (count_ff != '0);
                        tos_in   = dq_data.value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  smx_pkg::DOP_ADD, smx_pkg::DOP_MUL: begin
                     if (count_ff >= CW'(2)) begin
                        rd_en    = 1'b1;
                        count_in = cnt_m1;
                        state_in = smx_pkg::BK_FINISH;
                        fin_in   = (dq_data.op == smx_pkg::DOP_ADD) ?
                                   smx_pkg::FIN_ADD : smx_pkg::FIN_MUL;
                     end else begin
                        // missing operands read as zero
                        rq_push       = 1'b1;
                        rq_data.kind  = smx_pkg::KIND_UNDER;
                        rq_data.value = (dq_data.op == smx_pkg::DOP_ADD) ?
                                        smx_pkg::OPC_ADD : smx_pkg::OPC_MUL;
                        tos_in        = ((count_ff != '0) && (dq_data.op == smx_pkg::DOP_ADD))
                                        ? tos_ff : '0;
                        count_in      = CW'(1);
                     end
                  end
                  smx_pkg::DOP_OUT: begin
                     rq_push = 1'b1;
                     if (count_ff == '0) begin
                        rq_data.kind  = smx_pkg::KIND_UNDER;
                        rq_data.value = smx_pkg::OPC_OUT;
                     end else begin
                        rq_data.kind  = smx_pkg::KIND_OUT;
                        rq_data.value = tos_ff;
                        count_in      = cnt_m1;
                        if (count_ff >= CW'(2)) begin
                           rd_en    = 1'b1;
                           state_in = smx_pkg::BK_FINISH;
                           fin_in   = smx_pkg::FIN_LOAD;
                        end
                     end
                  end
                  smx_pkg::DOP_EMIT: begin
                     rq_push = 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (dq_data.last) begin
                  count_in = '0;
               end
            end
         end
         smx_pkg::BK_FINISH: begin
            state_in = smx_pkg::BK_ISSUE;
            case (fin_ff)
               smx_pkg::FIN_ADD: tos_in = tos_ff + rd_data;
               smx_pkg::FIN_MUL: tos_in = product;
               default:          tos_in = rd_data;
            endcase
         end
         default: begin
            state_in = smx_pkg::BK_ISSUE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smx_pkg::BK_ISSUE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
      fin_ff <= fin_in;
   end

endmodule

`default_nettype wire

@@ src/stack_machine_executor.sv @@
// Top level of the stack machine executor.
// Uses smx_pkg, smx_front, smx_queue and smx_back.
//  - Input channel: a program word is taken on a clock edge with req_push high
//    and req_full low. req_data carries code_word and last_word.
//  - Result channel: while rsp_empty is low, rsp_data shows the oldest result
//    word (kind, value); it is consumed on an edge with rsp_pop high.
//  - A word that produces a result reaches rsp_data through the decode queue
//    and the result queue, if the executor is idle and the result queue has room.
//  - Push immediates and words that emit a status need only the back end's
//    issue state; add, mul and an out with two or more stack entries also
//    need its finish state for the registered stack memory read. The front
//    end takes one word per cycle into a two-entry decode queue while not full.
//  - If the receiver stops popping, the two-entry result queue fills, the
//    executor stops, the decode queue fills and req_full rises. No word is
//    lost or repeated.
//  - Reset (synchronous, active high) empties both queues and the stack and
//    clears the push-immediate and halted state; stack memory contents are
//    not cleared, as only written entries are ever read.
//  - After the word marked last, the stack and state clear for the next
//    program.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_executor #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire smx_pkg::smx_req_type req_data,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output smx_pkg::smx_rsp_type      rsp_data
);

   localparam int DEC_W = $bits(smx_pkg::smx_dec_type);
   localparam int RSP_W = $bits(smx_pkg::smx_rsp_type);

   logic                 dq_push, dq_pop, dq_empty;
   smx_pkg::smx_dec_type dq_wr_data, dq_rd_data;
   logic [DEC_W-1:0]     dq_rd_bits;
   logic                 rq_push, rq_full;
   smx_pkg::smx_rsp_type rq_wr_data;
   logic [RSP_W-1:0]     rq_rd_bits;

   smx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .dq_full  (req_full),
      .dq_push  (dq_push),
      .dq_data  (dq_wr_data)
   );

   smx_queue #(
      .WIDTH (DEC_W),
      .DEPTH (2)
   ) u_dec_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (dq_push),
      .wr_data (DEC_W'(dq_wr_data)),
      .full    (req_full),
      .pop     (dq_pop),
      .rd_data (dq_rd_bits),
      .empty   (dq_empty)
   );

   assign dq_rd_data = smx_pkg::smx_dec_type'(dq_rd_bits);

   smx_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .dq_empty (dq_empty),
      .dq_data  (dq_rd_data),
      .dq_pop   (dq_pop),
      .rq_full  (rq_full),
      .rq_push  (rq_push),
      .rq_data  (rq_wr_data)
   );

   smx_queue #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rq_push),
      .wr_data (RSP_W'(rq_wr_data)),
      .full    (rq_full),
      .pop     (rsp_pop),
      .rd_data (rq_rd_bits),
      .empty   (rsp_empty)
   );

   assign rsp_data = smx_pkg::smx_rsp_type'(rq_rd_bits);

endmodule

`default_nettype wire

@@ src/smx_checker.sv @@
// Port-level checks for stack_machine_executor, bound to the top level.
// Uses smx_pkg and stack_machine_executor_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stack_machine_executor_macros.svh"

module smx_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_push,
   input wire logic                 req_full,
   input wire smx_pkg::smx_req_type req_data,
   input wire logic                 rsp_empty,
   input wire logic                 rsp_pop,
   input wire smx_pkg::smx_rsp_type rsp_data
);

   logic shown;
   logic status_zero;
   logic req_seen;

   assign shown       = !rsp_empty;
   assign status_zero = (rsp_data.kind == smx_pkg::KIND_HALT) ||
                        (rsp_data.kind == smx_pkg::KIND_NONE);
   assign req_seen    = req_push && !req_full && !req_data.last_word;

   // no result word right after reset
   `SMX_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, rsp_empty)
   // a waiting word holds until popped
   `SMX_ASSERT_NEXT(a_rsp_hold, clock, reset, shown && !rsp_pop, shown && $stable(rsp_data))
   // kind stays inside its code range
   `SMX_ASSERT_IMPLY(a_kind_range, clock, reset, shown, rsp_data.kind <= smx_pkg::KIND_OVER)
   // halted and none statuses carry zero
   `SMX_ASSERT_IMPLY(a_status_zero, clock, reset, shown && status_zero, rsp_data.value == 0)
   // overflow words carry the push opcode (checked while a non-last word is taken)
   `SMX_ASSERT_IMPLY(a_over_value, clock, reset,
      shown && (rsp_data.kind == smx_pkg::KIND_OVER) && req_seen,
      rsp_data.value == smx_pkg::OPC_PUSH)

endmodule

bind stack_machine_executor smx_checker u_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// Testbench for stack_machine_executor: random and directed program words, predicted results.
// Depends on smx_pkg and the stack_machine_executor RTL.
`timescale 1ns / 1ps

module tb;
   import smx_pkg::*;

   localparam int DEPTH     = 64;
   localparam int N_WORDS   = 1700;
   localparam int MAX_CYCLE = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   smx_req_type req_data = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   smx_rsp_type rsp_data;

   stack_machine_executor #(.STACK_DEPTH(DEPTH)) uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   smx_req_type pend_words[$];
   smx_rsp_type expected_rsp[$];

   logic [31:0] stk_mem [0:DEPTH-1];
   int          stk_cnt = 0;
   bit          imm_wait = 0;
   bit          halted = 0;

   int  errors = 0;
   int  words_in = 0;
   int  rsp_seen = 0;
   int  programs = 0;
   int  cycles = 0;
   bit  word_taken = 0;
   bit  quiet;

   assign quiet = (words_in >= 600) && (words_in < 1000);

   // executes one word on the local copy of the machine
   task automatic exec_word(input smx_req_type w);
      logic [31:0] opc, a, b;
      bit          emit, ok_a, ok_b;
      smx_rsp_type r;
      opc  = w.code_word;
      emit = 0;
      r    = '0;
      if (halted) begin
         imm_wait = 0;
      end else if (imm_wait) begin
         imm_wait = 0;
         if (stk_cnt < DEPTH) begin
            stk_mem[stk_cnt] = opc;
            stk_cnt++;
         end else begin
            emit = 1; r.kind = KIND_OVER; r.value = OPC_PUSH;
         end
      end else begin
         case (opc)
            OPC_PUSH: imm_wait = 1;
            OPC_ADD, OPC_MUL: begin
               ok_a = stk_cnt > 0;
               a = ok_a ? stk_mem[stk_cnt-1] : 32'd0;
               if (ok_a) stk_cnt--;
               ok_b = stk_cnt > 0;
               b = ok_b ? stk_mem[stk_cnt-1] : 32'd0;
               if (ok_b) stk_cnt--;
               stk_mem[stk_cnt] = (opc == OPC_ADD) ? a + b : a * b;
               stk_cnt++;
               if (!(ok_a && ok_b)) begin
                  emit = 1; r.kind = KIND_UNDER; r.value = opc;
               end
            end
            OPC_OUT: begin
               emit = 1;
               if (stk_cnt > 0) begin
                  stk_cnt--;
                  r.kind = KIND_OUT; r.value = stk_mem[stk_cnt];
               end else begin
                  r.kind = KIND_UNDER; r.value = opc;
               end
            end
            OPC_HLT: begin
               halted = 1;
               emit = 1; r.kind = KIND_HALT; r.value = 0;
            end
            OPC_NONE: begin
               emit = 1; r.kind = KIND_NONE; r.value = 0;
            end
            default: begin
               emit = 1; r.kind = KIND_UNKNOWN; r.value = opc;
            end
         endcase
      end
      if (w.last_word) begin
         stk_cnt = 0; imm_wait = 0; halted = 0;
      end
      if (emit) expected_rsp.push_back(r);
   endtask

   task automatic add_word(input logic [31:0] w, input bit is_last);
      smx_req_type it;
      it.code_word = w;
      it.last_word = is_last;
      pend_words.push_back(it);
   endtask

   function automatic logic [31:0] rand_imm();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 9);
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // one program; fill programs push DEPTH-1 to DEPTH+4 immediates, so may overflow the stack
   task automatic gen_program(input bit fill);
      logic [31:0] prog[$];
      int          d, n_ops, r;
      d = 0;
      if (fill) begin
         n_ops = $urandom_range(DEPTH - 1, DEPTH + 4);
         for (int i = 0; i < n_ops; i++) begin
            prog.push_back(OPC_PUSH);
            prog.push_back(rand_imm());
         end
         prog.push_back(OPC_ADD);
         prog.push_back(OPC_MUL);
         for (int i = $urandom_range(1, 4); i > 0; i--) prog.push_back(OPC_OUT);
      end else begin
         n_ops = $urandom_range(1, 24);
         for (int i = 0; i < n_ops; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40 || (d < 2 && r < 55)) begin
               prog.push_back(OPC_PUSH);
               prog.push_back(rand_imm());
               d++;
            end else if (r < 70) begin
               prog.push_back((r < 55) ? OPC_ADD : OPC_MUL);
               d = (d > 2 ? d - 2 : 0) + 1;
            end else if (r < 90) begin
               prog.push_back(OPC_OUT);
               d = d > 0 ? d - 1 : 0;
            end else begin
               case ($urandom_range(0, 3))
                  0: prog.push_back(OPC_NONE);
                  1: prog.push_back(OPC_HLT);
                  2: prog.push_back($urandom_range(6, 32'h7fff_ffff));
                  default: prog.push_back($urandom | 32'h8000_0000);
               endcase
            end
         end
         if ($urandom_range(0, 9) == 0) prog.push_back(OPC_PUSH);
      end
      foreach (prog[i]) add_word(prog[i], i == prog.size() - 1);
      programs++;
   endtask

   initial begin
      // directed: status codes, underflow, wraparound, halt, push as last word
      add_word(OPC_NONE, 0);
      add_word(OPC_OUT, 0);
      add_word(OPC_ADD, 0);
      add_word(OPC_OUT, 0);
      add_word(OPC_MUL, 0);
      add_word(OPC_PUSH, 0);
      add_word(32'h7fff_ffff, 0);
      add_word(OPC_PUSH, 0);
      add_word(32'h8000_0000, 0);
      add_word(OPC_ADD, 0);
      add_word(OPC_OUT, 0);
      add_word(OPC_PUSH, 0);
      add_word(32'hffff_ffff, 0);
      add_word(OPC_PUSH, 0);
      add_word(32'hffff_ffff, 0);
      add_word(OPC_MUL, 0);
      add_word(OPC_OUT, 0);
      add_word(32'hffff_ffff, 0);
      add_word(32'd6, 0);
      add_word(OPC_HLT, 0);
      add_word(OPC_PUSH, 0);
      add_word(OPC_OUT, 1);
      add_word(OPC_PUSH, 1);
      programs = 2;
      while (pend_words.size() < N_WORDS + 23) gen_program(programs % 12 == 5);

      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pend_words.size() != 0 || req_push) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, expected_rsp.size());
         errors++;
      end
      $display("tb: %0d words in %0d programs, %0d result words checked",
               words_in, programs, rsp_seen);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // input side: new word only after the previous one was taken
   always @(negedge clock) begin
      if (!reset && (!req_push || word_taken)) begin
         if (pend_words.size() != 0 && (quiet || $urandom_range(0, 99) >= 20)) begin
            req_data <= pend_words.pop_front();
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) rsp_pop <= quiet || ($urandom_range(0, 99) >= 20);
   end

   always @(posedge clock) begin
      smx_rsp_type e;
      cycles++;
      if (cycles > MAX_CYCLE) begin
         $display("%0t: timeout", $time);
         $display("tb: done, errors");
         $finish;
      end
      word_taken = 0;
      if (!reset) begin
         if (req_push && !req_full) begin
            exec_word(req_data);
            words_in++;
            word_taken = 1;
         end
         if (rsp_pop && !rsp_empty) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected word kind %0d value %h", $time,
                        rsp_data.kind, rsp_data.value);
               errors++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.kind !== e.kind) begin
                  $display("%0t: kind expected %0d actual %0d", $time, e.kind, rsp_data.kind);
                  errors++;
               end
               if (rsp_data.value !== e.value) begin
                  $display("%0t: value expected %h actual %h", $time, e.value, rsp_data.value);
                  errors++;
               end
            end
         end
      end
   end

endmodule
